/* src/esc_pkg.sv */
package esc_pkg;

   // field widths
   localparam int unsigned SecsW   = 32;
   localparam int unsigned YearW   = 12;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned DayW    = 5;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;

   // internal widths
   localparam int unsigned DaysW   = 16;  // whole days fit below 2**16
   localparam int unsigned QuotW   = 16;
   localparam int unsigned PcW     = 4;
   localparam int unsigned Mod4W   = 2;
   localparam int unsigned Mod100W = 7;
   localparam int unsigned Mod400W = 9;

   localparam logic [YearW-1:0]   EpochYear   = YearW'(1990);
   localparam logic [Mod4W-1:0]   EpochMod4   = Mod4W'(1990 % 4);
   localparam logic [Mod100W-1:0] EpochMod100 = Mod100W'(1990 % 100);
   localparam logic [Mod400W-1:0] EpochMod400 = Mod400W'(1990 % 400);

   localparam logic [DaysW-1:0] YearLen     = DaysW'(365);
   localparam logic [DaysW-1:0] LeapYearLen = DaysW'(366);
   localparam logic [MonthW-1:0] LastMonth  = MonthW'(11);

   // quotients by reciprocal multiplication: 86400 = 675 << 7, 3600 = 225 << 4,
   // 60 = 15 << 2; each reciprocal is rounded up and exact over its numerator range
   localparam int unsigned DayPreShift   = 7;
   localparam int unsigned DayNumW       = SecsW - DayPreShift;
   localparam int unsigned DayRecipShift = 35;
   localparam int unsigned DayProdW      = DayNumW + 26;
   localparam logic [DayProdW-1:0] DayRecip = DayProdW'(50903317);

   localparam int unsigned HourPreShift   = 4;
   localparam int unsigned HourNumW       = 13;  // remainder of a day is below 2**17
   localparam int unsigned HourRecipShift = 21;
   localparam int unsigned HourProdW      = HourNumW + 14;
   localparam logic [HourProdW-1:0] HourRecip = HourProdW'(9321);

   localparam int unsigned MinPreShift   = 2;
   localparam int unsigned MinNumW       = 10;  // remainder of an hour is below 2**12
   localparam int unsigned MinRecipShift = 14;
   localparam int unsigned MinProdW      = MinNumW + 11;
   localparam logic [MinProdW-1:0] MinRecip = MinProdW'(1093);

   localparam logic [SecsW-1:0] DaySecs  = SecsW'(86400);
   localparam logic [SecsW-1:0] HourSecs = SecsW'(3600);
   localparam logic [SecsW-1:0] MinSecs  = SecsW'(60);

   // opcodes
   localparam logic [2:0] OP_NOP   = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_QUOT  = 3'd2;
   localparam logic [2:0] OP_REM   = 3'd3;
   localparam logic [2:0] OP_YEAR  = 3'd4;
   localparam logic [2:0] OP_MONTH = 3'd5;
   localparam logic [2:0] OP_EMIT  = 3'd6;

   // divisor select
   localparam logic [1:0] DIV_DAY  = 2'd0;
   localparam logic [1:0] DIV_HOUR = 2'd1;
   localparam logic [1:0] DIV_MIN  = 2'd2;

   // quotient destination
   localparam logic [1:0] DST_NONE = 2'd0;
   localparam logic [1:0] DST_DAYS = 2'd1;
   localparam logic [1:0] DST_HOUR = 2'd2;
   localparam logic [1:0] DST_MIN  = 2'd3;

   // hold condition
   localparam logic [1:0] CND_NEXT     = 2'd0;
   localparam logic [1:0] CND_WAIT_IN  = 2'd1;
   localparam logic [1:0] CND_LOOP     = 2'd2;
   localparam logic [1:0] CND_WAIT_OUT = 2'd3;

   localparam logic [PcW-1:0] PcStart = PcW'(0);
   localparam logic [PcW-1:0] PcLast  = PcW'(9);

   typedef struct packed {
      logic [2:0]     op;
      logic [1:0]     div_sel;
      logic [1:0]     dst;
      logic [1:0]     cond;
      logic [PcW-1:0] next;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PcW-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, div_sel: DIV_DAY, dst: DST_NONE, cond: CND_NEXT, next: PcStart};
      case (pc)
         4'd0:  w = '{OP_LOAD,  DIV_DAY,  DST_NONE, CND_WAIT_IN,  4'd1};
         4'd1:  w = '{OP_QUOT,  DIV_DAY,  DST_NONE, CND_NEXT,     4'd2};
         4'd2:  w = '{OP_REM,   DIV_DAY,  DST_DAYS, CND_NEXT,     4'd3};
         4'd3:  w = '{OP_QUOT,  DIV_HOUR, DST_NONE, CND_NEXT,     4'd4};
         4'd4:  w = '{OP_REM,   DIV_HOUR, DST_HOUR, CND_NEXT,     4'd5};
         4'd5:  w = '{OP_QUOT,  DIV_MIN,  DST_NONE, CND_NEXT,     4'd6};
         4'd6:  w = '{OP_REM,   DIV_MIN,  DST_MIN,  CND_NEXT,     4'd7};
         4'd7:  w = '{OP_YEAR,  DIV_DAY,  DST_NONE, CND_LOOP,     4'd8};
         4'd8:  w = '{OP_MONTH, DIV_DAY,  DST_NONE, CND_LOOP,     4'd9};
         4'd9:  w = '{OP_EMIT,  DIV_DAY,  DST_NONE, CND_WAIT_OUT, PcStart};
         default: w = '{OP_NOP, DIV_DAY,  DST_NONE, CND_NEXT,     PcStart};
      endcase
      return w;
   endfunction

   function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                    input logic leap);
      logic [DayW-1:0] len;
      case (m)
         4'd1:    len = leap ? DayW'(29) : DayW'(28);
         4'd3, 4'd5, 4'd8, 4'd10: len = DayW'(30);
         default: len = DayW'(31);
      endcase
      return len;
   endfunction

endpackage

/* src/esc_req_if.sv */
interface esc_req_if;
   import esc_pkg::*;
   logic             valid;
   logic             ready;
   logic [SecsW-1:0] elapsed_seconds;

   modport source (output valid, output elapsed_seconds, input ready);
   modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

/* src/esc_rsp_if.sv */
interface esc_rsp_if;
   import esc_pkg::*;
   logic               valid;
   logic               ready;
   logic [YearW-1:0]   year;
   logic [MonthW-1:0]  month;
   logic [DayW-1:0]    day_of_month;
   logic [HourW-1:0]   hour;
   logic [MinuteW-1:0] minute;
   logic [SecondW-1:0] second;

   modport source (output valid, output year, output month, output day_of_month,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input hour, input minute, input second, output ready);
endinterface

/* src/epoch_seconds_to_calendar.sv */
// Converts a 32-bit count of seconds since 1990-01-01 00:00:00 into a Gregorian
// date and time of day, one result beat per request beat. A small microcode
// program in a constant table splits off days, hours and minutes by reciprocal
// multiplication (a quotient step and a remainder step each), then strips whole
// years one per cycle (up to 136) and months one per cycle (up to 11) before it
// registers the result. The next request is taken as soon as the result is
// registered, even while that result still waits on rsp_chan.
module epoch_seconds_to_calendar
   import esc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   esc_req_if.sink    req_chan,
   esc_rsp_if.source  rsp_chan
);

   logic [PcW-1:0]     pc_ff, pc_in;
   logic [SecsW-1:0]   acc_ff, acc_in;
   logic [QuotW-1:0]   quot_ff, quot_in;
   logic [DaysW-1:0]   days_ff, days_in;
   logic [HourW-1:0]   hour_ff, hour_in;
   logic [MinuteW-1:0] min_ff, min_in;
   logic [YearW-1:0]   year_ff, year_in;
   logic [Mod4W-1:0]   mod4_ff, mod4_in;
   logic [Mod100W-1:0] mod100_ff, mod100_in;
   logic [Mod400W-1:0] mod400_ff, mod400_in;
   logic [MonthW-1:0]  month_ff, month_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [YearW-1:0]   rsp_year_ff;
   logic [MonthW-1:0]  rsp_month_ff;
   logic [DayW-1:0]    rsp_day_ff;
   logic [HourW-1:0]   rsp_hour_ff;
   logic [MinuteW-1:0] rsp_min_ff;
   logic [SecondW-1:0] rsp_sec_ff;

   ucode_type          uw;
   logic               req_fire;
   logic               out_free;
   logic               leap;
   logic [DaysW-1:0]   ylen;
   logic [DaysW-1:0]   mlen;
   logic [DayProdW-1:0]  day_prod;
   logic [HourProdW-1:0] hour_prod;
   logic [MinProdW-1:0]  min_prod;
   logic               year_more;
   logic               month_more;
   logic               hold;
   logic               emit;

   assign uw       = ucode_rom(pc_ff);
   assign req_chan.ready = (uw.op == OP_LOAD);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign leap = (mod400_ff == '0) || ((mod100_ff != '0) && (mod4_ff == '0));
   assign ylen = leap ? LeapYearLen : YearLen;
   assign mlen = DaysW'(month_length(month_ff, leap));

   // quotient = (numerator * reciprocal) >> shift
   assign day_prod  = DayProdW'(acc_ff[SecsW-1:DayPreShift]) * DayRecip;
   assign hour_prod = HourProdW'(acc_ff[HourNumW+HourPreShift-1:HourPreShift]) * HourRecip;
   assign min_prod  = MinProdW'(acc_ff[MinNumW+MinPreShift-1:MinPreShift]) * MinRecip;

   assign year_more  = (days_ff >= ylen);
   assign month_more = (month_ff < LastMonth) && (days_ff >= mlen);

   always_comb begin
      case (uw.cond)
         CND_WAIT_IN:  hold = !req_fire;
         CND_LOOP: begin
            case (uw.op)
               OP_YEAR:    hold = year_more;
               OP_MONTH:   hold = month_more;
               default:    hold = 1'b0;
            endcase
         end
         CND_WAIT_OUT: hold = !out_free;
         default:      hold = 1'b0;
      endcase
   end

   assign emit  = (uw.op == OP_EMIT) && out_free;
   assign pc_in = hold ? pc_ff : uw.next;

   // datapath driven by the current control word
   always_comb begin
      acc_in    = acc_ff;
      quot_in   = quot_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      min_in    = min_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;

      unique case (uw.dst)
         DST_DAYS: days_in = quot_ff;
         DST_HOUR: hour_in = quot_ff[HourW-1:0];
         DST_MIN:  min_in  = quot_ff[MinuteW-1:0];
         default: ;
      endcase

      unique case (uw.op)
         OP_LOAD: begin
            acc_in    = req_chan.elapsed_seconds;
            year_in   = EpochYear;
            mod4_in   = EpochMod4;
            mod100_in = EpochMod100;
            mod400_in = EpochMod400;
            month_in  = '0;
         end
         OP_QUOT: begin
            unique case (uw.div_sel)
               DIV_HOUR: quot_in = QuotW'(hour_prod[HourProdW-1:HourRecipShift]);
               DIV_MIN:  quot_in = QuotW'(min_prod[MinProdW-1:MinRecipShift]);
               default:  quot_in = QuotW'(day_prod[DayProdW-1:DayRecipShift]);
            endcase
         end
         OP_REM: begin
            unique case (uw.div_sel)
               DIV_HOUR: acc_in = acc_ff - SecsW'(quot_ff) * HourSecs;
               DIV_MIN:  acc_in = acc_ff - SecsW'(quot_ff) * MinSecs;
               default:  acc_in = acc_ff - SecsW'(quot_ff) * DaySecs;
            endcase
         end
         OP_YEAR: begin
            if (year_more) begin
               days_in   = days_ff - ylen;
               year_in   = year_ff + YearW'(1);
               mod4_in   = mod4_ff + Mod4W'(1);
               mod100_in = (mod100_ff == Mod100W'(99)) ? '0 : mod100_ff + Mod100W'(1);
               mod400_in = (mod400_ff == Mod400W'(399)) ? '0 : mod400_ff + Mod400W'(1);
            end
         end
         OP_MONTH: begin
            if (month_more) begin
               days_in  = days_ff - mlen;
               month_in = month_ff + MonthW'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PcStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      quot_ff   <= quot_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
   end

   // result register, the seconds are what the minute division leaves
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_year_ff  <= year_ff;
         rsp_month_ff <= month_ff + MonthW'(1);
         rsp_day_ff   <= days_ff[DayW-1:0] + DayW'(1);
         rsp_hour_ff  <= hour_ff;
         rsp_min_ff   <= min_ff;
         rsp_sec_ff   <= acc_ff[SecondW-1:0];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.year         = rsp_year_ff;
   assign rsp_chan.month        = rsp_month_ff;
   assign rsp_chan.day_of_month = rsp_day_ff;
   assign rsp_chan.hour         = rsp_hour_ff;
   assign rsp_chan.minute       = rsp_min_ff;
   assign rsp_chan.second       = rsp_sec_ff;

`ifndef SYNTHESIS
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PcLast)
      else $error("step counter left the program");

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pc_ff == PcW'(1)))
      else $error("accepted beat did not start the day division");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      emit |-> (month_ff <= LastMonth) && (days_ff < DaysW'(31))
               && (hour_ff < HourW'(24)) && (min_ff < MinuteW'(60))
               && (acc_ff < SecsW'(60)))
      else $error("calendar fields out of range at emit");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("result not presented after emit");
`endif

endmodule

/* bench/tb.sv */
module tb
   import esc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [YearW-1:0]   year;
      logic [MonthW-1:0]  month;
      logic [DayW-1:0]    day_of_month;
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } date_time_type;

   typedef struct packed {
      logic [SecsW-1:0] secs;
      logic             typed;
      date_time_type    want;
   } stim_row_type;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned FIRST_YEAR    = 1990;
   localparam int unsigned LAST_DAY      = 49709;  // last whole day below 2**32 seconds
   localparam int unsigned RANDOM_ITEMS  = 1350;
   localparam int unsigned DRAIN_CYCLES  = 250;
   localparam int unsigned NUM_DIRECTED  = 22;

   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam date_time_type NO_DATE = '0;

   // typed-in rows carry their own expectation, the rest go through the predictor
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{32'd0,          1'b1, '{12'd1990, 4'd1, 5'd1, 5'd0,  6'd0,  6'd0}},
      '{32'd1,          1'b0, NO_DATE},
      '{32'd59,         1'b0, NO_DATE},
      '{32'd60,         1'b0, NO_DATE},
      '{32'd3599,       1'b0, NO_DATE},
      '{32'd3600,       1'b0, NO_DATE},
      '{32'd86399,      1'b1, '{12'd1990, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
      '{32'd86400,      1'b0, NO_DATE},
      '{32'd31535999,   1'b0, NO_DATE},
      '{32'd31536000,   1'b0, NO_DATE},
      '{32'd68169599,   1'b0, NO_DATE},
      '{32'd68169600,   1'b0, NO_DATE},
      '{32'd68256000,   1'b0, NO_DATE},
      '{32'd320630400,  1'b0, NO_DATE},
      '{32'd3476390399, 1'b0, NO_DATE},
      '{32'd3476390400, 1'b0, NO_DATE},
      '{32'h5555_5555,  1'b0, NO_DATE},
      '{32'hAAAA_AAAA,  1'b0, NO_DATE},
      '{32'h7FFF_FFFF,  1'b0, NO_DATE},
      '{32'h8000_0000,  1'b0, NO_DATE},
      '{32'hFFFF_FFFE,  1'b0, NO_DATE},
      '{32'hFFFF_FFFF,  1'b1, '{12'd2126, 4'd2, 5'd7, 5'd6,  6'd28, 6'd15}}
   };

   logic clock;
   logic reset;

   esc_req_if req_chan ();
   esc_rsp_if rsp_chan ();

   epoch_seconds_to_calendar u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_time_type calendar_due [$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   logic [11:0] rsp_cycle      = '0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic date_time_type to_calendar(input logic [SecsW-1:0] secs);
      date_time_type r;
      int unsigned days;
      int unsigned rem;
      int unsigned yr;
      int unsigned mo;
      int unsigned mlen;
      bit          leap;
      days = secs / SECS_PER_DAY;
      rem  = secs % SECS_PER_DAY;
      yr   = FIRST_YEAR;
      mo   = 0;
      leap = 1'b0;
      while (1) begin
         leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
         if (days < (leap ? 366 : 365))
            break;
         days -= leap ? 366 : 365;
         yr++;
      end
      while (mo < 11) begin
         mlen = (mo == 1 && leap) ? 29 : DAYS_IN_MONTH[mo];
         if (days < mlen)
            break;
         days -= mlen;
         mo++;
      end
      r.year         = YearW'(yr);
      r.month        = MonthW'(mo + 1);
      r.day_of_month = DayW'(days + 1);
      r.hour         = HourW'(rem / SECS_PER_HOUR);
      r.minute       = MinuteW'((rem % SECS_PER_HOUR) / 60);
      r.second       = SecondW'(rem % 60);
      return r;
   endfunction

   function automatic logic [SecsW-1:0] pick_seconds();
      longint unsigned v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         // first or last second of a day
         4, 5: v = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY
                   + ($urandom_range(0, 1) ? 0 : SECS_PER_DAY - 1);
         // last minute of a day
         6: v = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY
                + $urandom_range(SECS_PER_DAY - 60, SECS_PER_DAY - 1);
         // first dozen years, short runs through the year loop
         7, 8: v = $urandom_range(0, 400_000_000);
         default: v = $urandom_range(0, 200_000);
      endcase
      return SecsW'(v);
   endfunction

   task automatic send_seconds(input logic [SecsW-1:0] secs, input logic typed,
                               input date_time_type want);
      int unsigned gap;
      req_chan.valid           <= 1'b1;
      req_chan.elapsed_seconds <= secs;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      calendar_due.push_back(typed ? want : to_calendar(secs));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         case ($urandom_range(0, 15))
            0:       gap = $urandom_range(20, 200);
            1, 2, 3: gap = 0;
            default: gap = $urandom_range(1, 8);
         endcase
         if (gap != 0) begin
            req_chan.valid           <= 1'b0;
            req_chan.elapsed_seconds <= $urandom;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      end
   endtask

   // receiver: free running, random stalls, a fixed stall comb, then heavy stalls
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 12'd1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case (rsp_cycle[11:10])
            2'd0:    rsp_chan.ready <= 1'b1;
            2'd1:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_chan.ready <= (rsp_cycle[4:0] < 5'd20);
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      date_time_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (calendar_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat, expected none got %0d-%0d-%0d %0d:%0d:%0d",
                     $time, rsp_chan.year, rsp_chan.month, rsp_chan.day_of_month,
                     rsp_chan.hour, rsp_chan.minute, rsp_chan.second);
         end else begin
            want = calendar_due.pop_front();
            check_field("year",         want.year,         rsp_chan.year);
            check_field("month",        want.month,        rsp_chan.month);
            check_field("day_of_month", want.day_of_month, rsp_chan.day_of_month);
            check_field("hour",         want.hour,         rsp_chan.hour);
            check_field("minute",       want.minute,       rsp_chan.minute);
            check_field("second",       want.second,       rsp_chan.second);
         end
      end
   end

   initial begin
      int unsigned i;
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.elapsed_seconds = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++)
         send_seconds(DIRECTED[i].secs, DIRECTED[i].typed, DIRECTED[i].want);
      for (i = 0; i < RANDOM_ITEMS; i++)
         send_seconds(pick_seconds(), 1'b0, NO_DATE);
      req_chan.valid <= 1'b0;

      while (calendar_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8ms;
      $display("%0t: timeout, %0d beats still due", $time, calendar_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
